// ===== sv/assert_macros.svh =====
// Assertion macros used by the allocator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define PFBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define PFBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pfba_pkg.sv =====
// Types, codes and fixed widths of the page frame bitmap allocator.
package pfba_pkg;

  localparam int CNT_W      = 21;
  localparam int KIB_W      = 22;
  localparam int ADDR_W     = 32;
  localparam int PAGE_SHIFT = 12;
  localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_W      = 22;

  localparam logic [CNT_W-1:0] COUNT_MAX      = '1;
  localparam logic [KIB_W:0]   LOW_MEMORY_KIB = 23'd1024;
  localparam logic [CNT_W-1:0] RESERVED_RESET = 21'd1024;

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NO_FREE      = 2'd1,
    ST_BEYOND       = 2'd2,
    ST_ALREADY_FREE = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UPPER_KIB = 1'b0,
    CFG_RESERVED  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [ADDR_W-1:0] free_address;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] page_address;
    logic [CNT_W-1:0]  free_count;
  } res_t;

endpackage

// ===== sv/pfba_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module pfba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32768
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry and read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/pfba_word_scan.sv =====
// Lowest-clear-bit finder for one bitmap word.
module pfba_word_scan #(
  parameter int WORD_BITS = 32
) (
  input  logic [WORD_BITS-1:0]         word_i,
  output logic                         full_o,
  output logic [$clog2(WORD_BITS)-1:0] idx_o,
  output logic [WORD_BITS-1:0]         onehot_o
);

  localparam int BW = $clog2(WORD_BITS);

  // Isolate the lowest clear bit: the carry of +1 stops there
  assign onehot_o = ~word_i & (word_i + WORD_BITS'(1));
  assign full_o   = &word_i;

  // Encode the one-hot position
  always_comb begin
    idx_o = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (onehot_o[i]) begin
        idx_o = idx_o | BW'(i);
      end
    end
  end

endmodule

// ===== sv/pfba_page_div.sv =====
// Two-stage split of a page number into bitmap word, bit and word base page.
module pfba_page_div #(
  parameter int WORD_BITS = 32,
  parameter int AW        = 15
) (
  input  logic                             clk_i,
  input  logic                             en1_i,
  input  logic                             en2_i,
  input  logic [pfba_pkg::PAGE_W-1:0]      page_i,
  output logic [AW-1:0]                    word_o,
  output logic [$clog2(WORD_BITS)-1:0]     bit_o,
  output logic [pfba_pkg::PAGE_W-1:0]      base_o
);

  localparam int BW = $clog2(WORD_BITS);
  localparam int PW = pfba_pkg::PAGE_W;
  localparam int SH = PW + BW;
  localparam int RW = PW + 2;
  localparam longint unsigned RECIP =
    ((longint'(1) << SH) + longint'(WORD_BITS) - 1) / longint'(WORD_BITS);

  logic [PW-1:0]    page_q;
  logic [PW-1:0]    quo_q;
  logic [PW+RW-1:0] prod;
  logic [PW-1:0]    base;
  logic [PW-1:0]    rem;
  logic [AW-1:0]    word_q;
  logic [BW-1:0]    bit_q;
  logic [PW-1:0]    base_q;

  // Quotient by reciprocal multiply; exact for every page number
  assign prod = PW'(0) + (RW'(RECIP) * page_i);

  // Base page and bit offset from the registered quotient
  assign base = PW'(quo_q * PW'(WORD_BITS));
  assign rem  = page_q - base;

  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      page_q <= page_i;
      quo_q  <= PW'(prod >> SH);
    end
    if (en2_i) begin
      word_q <= quo_q[AW-1:0];
      bit_q  <= rem[BW-1:0];
      base_q <= base;
    end
  end

  assign word_o = word_q;
  assign bit_o  = bit_q;
  assign base_o = base_q;

endmodule

// ===== sv/page_frame_bitmap_allocator.sv =====
// Page frame bitmap allocator top level: command sequencer around the bitmap RAM.
// Unused command, full allocator or free beyond count: result in the cycle after start.
// Free: S_FREE_DIV, S_FREE_RD, S_FREE_CHK. Alloc: S_SCAN_RD, S_SCAN_CHK per word from the hint.
// Init: S_INIT_CALC, then S_INIT_SWEEP: ceil(page count / WORD_BITS) words, one a cycle.
// Throughput: one command at a time; start is taken again once busy is low.
// Reset clears control state; the bitmap is not swept, it stays unread until the first init.
`include "assert_macros.svh"

module page_frame_bitmap_allocator #(
  parameter int BITMAP_WORDS = 32768,
  parameter int WORD_BITS    = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  pfba_pkg::cmd_t                    cmd_i,
  output logic                              done_o,
  output pfba_pkg::res_t                    res_o,
  input  logic                              cfg_we_i,
  input  logic [pfba_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pfba_pkg::CFG_W-1:0]        cfg_wdata_i
);

  localparam int AW    = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int BW    = $clog2(WORD_BITS);
  localparam int CNT_W = pfba_pkg::CNT_W;
  localparam int POS_W = CNT_W + 1;
  localparam int PW    = pfba_pkg::PAGE_W;
  localparam longint unsigned CAPACITY = longint'(BITMAP_WORDS) * longint'(WORD_BITS);
  localparam logic [CNT_W-1:0] CAP_PAGES =
    (CAPACITY > longint'(pfba_pkg::COUNT_MAX)) ? pfba_pkg::COUNT_MAX : CNT_W'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT_CALC,
    S_INIT_SWEEP,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_FREE_DIV,
    S_FREE_RD,
    S_FREE_CHK
  } state_e;

  state_e                      state_q, state_d;
  logic [pfba_pkg::KIB_W-1:0]  kib_q, kib_d;
  logic [CNT_W-1:0]            rsv_q, rsv_d;
  logic [CNT_W-1:0]            page_count_q, page_count_d;
  logic [CNT_W-1:0]            free_q, free_d;
  logic [CNT_W-1:0]            reserve_q, reserve_d;
  logic [AW-1:0]               hint_w_q, hint_w_d;
  logic [CNT_W-1:0]            hint_base_q, hint_base_d;
  logic [AW-1:0]               cur_w_q, cur_w_d;
  logic [POS_W-1:0]            cur_base_q, cur_base_d;
  logic                        done_q, done_d;
  pfba_pkg::res_t              res_q, res_d;

  logic                        accept;
  logic [pfba_pkg::KIB_W:0]    kib_sum;
  logic [CNT_W-1:0]            pc_raw;
  logic [CNT_W-1:0]            pc_sat;
  logic [CNT_W-1:0]            rsv_sat;
  logic [PW-1:0]               free_page;
  logic [POS_W-1:0]            next_base;
  logic [POS_W-1:0]            rsv_left;
  logic [WORD_BITS-1:0]        part_mask;
  logic [POS_W-1:0]            found_page;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [WORD_BITS-1:0]        ram_wdata;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic [WORD_BITS-1:0]        ram_rdata;

  logic                        scan_full;
  logic [BW-1:0]               scan_idx;
  logic [WORD_BITS-1:0]        scan_onehot;

  logic                        div_en1;
  logic                        div_en2;
  logic [AW-1:0]               div_word;
  logic [BW-1:0]               div_bit;
  logic [PW-1:0]               div_base;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  // Page count from the upper plus low memory size, saturated at the bitmap capacity
  assign kib_sum = {1'b0, kib_q} + pfba_pkg::LOW_MEMORY_KIB;
  assign pc_raw  = kib_sum[pfba_pkg::KIB_W:2];
  assign pc_sat  = (pc_raw > CAP_PAGES) ? CAP_PAGES : pc_raw;
  assign rsv_sat = (rsv_q > page_count_q) ? page_count_q : rsv_q;

  assign free_page  = cmd_i.free_address[pfba_pkg::ADDR_W-1:pfba_pkg::PAGE_SHIFT];
  assign next_base  = cur_base_q + POS_W'(WORD_BITS);
  assign rsv_left   = POS_W'(reserve_q) - cur_base_q;
  assign part_mask  = ~({WORD_BITS{1'b1}} << rsv_left[BW-1:0]);
  assign found_page = cur_base_q + POS_W'(scan_idx);

  pfba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (BITMAP_WORDS)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pfba_word_scan #(
    .WORD_BITS (WORD_BITS)
  ) u_scan (
    .word_i   (ram_rdata),
    .full_o   (scan_full),
    .idx_o    (scan_idx),
    .onehot_o (scan_onehot)
  );

  pfba_page_div #(
    .WORD_BITS (WORD_BITS),
    .AW        (AW)
  ) u_div (
    .clk_i  (clk_i),
    .en1_i  (div_en1),
    .en2_i  (div_en2),
    .page_i (free_page),
    .word_o (div_word),
    .bit_o  (div_bit),
    .base_o (div_base)
  );

  // Sequence commands and compute next values
  always_comb begin
    state_d      = state_q;
    kib_d        = kib_q;
    rsv_d        = rsv_q;
    page_count_d = page_count_q;
    free_d       = free_q;
    reserve_d    = reserve_q;
    hint_w_d     = hint_w_q;
    hint_base_d  = hint_base_q;
    cur_w_d      = cur_w_q;
    cur_base_d   = cur_base_q;
    done_d       = 1'b0;
    res_d        = res_q;
    ram_we       = 1'b0;
    ram_waddr    = cur_w_q;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = cur_w_q;
    div_en1      = 1'b0;
    div_en2      = 1'b0;

    // Take configuration writes
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pfba_pkg::CFG_UPPER_KIB: kib_d = cfg_wdata_i[pfba_pkg::KIB_W-1:0];
        pfba_pkg::CFG_RESERVED:  rsv_d = cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d.page_address = '0;
          res_d.free_count   = free_q;
          res_d.status       = pfba_pkg::ST_OK;
          unique case (cmd_i.command)
            pfba_pkg::CMD_INIT: begin
              page_count_d = pc_sat;
              state_d      = S_INIT_CALC;
            end
            pfba_pkg::CMD_ALLOC: begin
              if (free_q == '0) begin
                res_d.status = pfba_pkg::ST_NO_FREE;
                done_d       = 1'b1;
              end else begin
                cur_w_d    = hint_w_q;
                cur_base_d = POS_W'(hint_base_q);
                state_d    = S_SCAN_RD;
              end
            end
            pfba_pkg::CMD_FREE: begin
              if (CNT_W'(free_page) >= page_count_q) begin
                res_d.status = pfba_pkg::ST_BEYOND;
                done_d       = 1'b1;
              end else begin
                div_en1 = 1'b1;
                state_d = S_FREE_DIV;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      // Clamp the reserve and set the free count
      S_INIT_CALC: begin
        reserve_d   = rsv_sat;
        free_d      = page_count_q - rsv_sat;
        hint_w_d    = '0;
        hint_base_d = '0;
        cur_w_d     = '0;
        cur_base_d  = '0;
        state_d     = S_INIT_SWEEP;
      end

      // Write one word a cycle: full, partial or clear
      S_INIT_SWEEP: begin
        if (cur_base_q >= POS_W'(page_count_q)) begin
          res_d.free_count = free_q;
          done_d           = 1'b1;
          state_d          = S_IDLE;
        end else begin
          ram_we = 1'b1;
          if (next_base <= POS_W'(reserve_q)) begin
            ram_wdata   = '1;
            hint_w_d    = cur_w_q + AW'(1);
            hint_base_d = next_base[CNT_W-1:0];
          end else if (cur_base_q < POS_W'(reserve_q)) begin
            ram_wdata = part_mask;
          end else begin
            ram_wdata = '0;
          end
          cur_w_d    = cur_w_q + AW'(1);
          cur_base_d = next_base;
        end
      end

      // Issue the read of the next candidate word, or report no free page past the page count
      S_SCAN_RD: begin
        if (cur_base_q >= POS_W'(page_count_q)) begin
          res_d.status = pfba_pkg::ST_NO_FREE;
          done_d       = 1'b1;
          state_d      = S_IDLE;
        end else begin
          ram_re  = 1'b1;
          state_d = S_SCAN_CHK;
        end
      end

      // Take the lowest clear bit or advance to the next word; a clear bit past the page count reports no free page
      S_SCAN_CHK: begin
        if (scan_full) begin
          cur_w_d    = cur_w_q + AW'(1);
          cur_base_d = next_base;
          state_d    = S_SCAN_RD;
        end else if (found_page >= POS_W'(page_count_q)) begin
          res_d.status = pfba_pkg::ST_NO_FREE;
          done_d       = 1'b1;
          state_d      = S_IDLE;
        end else begin
          ram_we             = 1'b1;
          ram_wdata          = ram_rdata | scan_onehot;
          free_d             = free_q - CNT_W'(1);
          hint_w_d           = cur_w_q;
          hint_base_d        = cur_base_q[CNT_W-1:0];
          res_d.page_address = {found_page[PW-1:0], {pfba_pkg::PAGE_SHIFT{1'b0}}};
          res_d.free_count   = free_q - CNT_W'(1);
          done_d             = 1'b1;
          state_d            = S_IDLE;
        end
      end

      S_FREE_DIV: begin
        div_en2 = 1'b1;
        state_d = S_FREE_RD;
      end

      S_FREE_RD: begin
        ram_re    = 1'b1;
        ram_raddr = div_word;
        state_d   = S_FREE_CHK;
      end

      // Clear the page bit unless it is already clear
      S_FREE_CHK: begin
        if (!ram_rdata[div_bit]) begin
          res_d.status = pfba_pkg::ST_ALREADY_FREE;
        end else begin
          ram_we           = 1'b1;
          ram_waddr        = div_word;
          ram_wdata        = ram_rdata & ~(WORD_BITS'(1) << div_bit);
          free_d           = free_q + CNT_W'(1);
          res_d.free_count = free_q + CNT_W'(1);
          if (CNT_W'(div_base) < hint_base_q) begin
            hint_w_d    = div_word;
            hint_base_d = CNT_W'(div_base);
          end
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state, configuration and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      kib_q        <= '0;
      rsv_q        <= pfba_pkg::RESERVED_RESET;
      page_count_q <= '0;
      free_q       <= '0;
      reserve_q    <= '0;
      hint_w_q     <= '0;
      hint_base_q  <= '0;
      cur_w_q      <= '0;
      cur_base_q   <= '0;
      done_q       <= 1'b0;
      res_q        <= '0;
    end else begin
      state_q      <= state_d;
      kib_q        <= kib_d;
      rsv_q        <= rsv_d;
      page_count_q <= page_count_d;
      free_q       <= free_d;
      reserve_q    <= reserve_d;
      hint_w_q     <= hint_w_d;
      hint_base_q  <= hint_base_d;
      cur_w_q      <= cur_w_d;
      cur_base_q   <= cur_base_d;
      done_q       <= done_d;
      res_q        <= res_d;
    end
  end

  `PFBA_ASSERT_NXT(a_accept_progress, clk_i, rst_ni, accept, busy || done_o, "start lost")
  `PFBA_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_o, !busy, "result while busy")
  `PFBA_ASSERT_IMP(a_err_no_addr, clk_i, rst_ni,
                   done_o && (res_o.status != pfba_pkg::ST_OK),
                   res_o.page_address == '0, "address on error")
  `PFBA_ASSERT_IMP(a_free_bound, clk_i, rst_ni, done_o,
                   res_o.free_count <= page_count_q, "free count above page count")

endmodule
